// ----- design/ssps_pkg.sv -----
// Shared constants, register indexes and control types of the speed-scaled pulse scheduler.
package ssps_pkg;

	localparam int IN_W   = 48;
	localparam int OUT_W  = 96;
	localparam int IDX_W  = 3;
	localparam int CFG_W  = 32;

	localparam logic [31:0] SAMPLE_PERIOD_MS = 32'd1000;
	localparam logic [7:0]  MIN_SATS         = 8'd4;
	localparam logic [15:0] AGE_LIMIT_MS     = 16'd2000;

	localparam logic [IDX_W-1:0] REG_SPEED_MIN    = 3'd0;
	localparam logic [IDX_W-1:0] REG_SPEED_MAX    = 3'd1;
	localparam logic [IDX_W-1:0] REG_INTERVAL_MIN = 3'd2;
	localparam logic [IDX_W-1:0] REG_INTERVAL_MAX = 3'd3;
	localparam logic [IDX_W-1:0] REG_DUTY_MIN     = 3'd4;
	localparam logic [IDX_W-1:0] REG_DUTY_MAX     = 3'd5;
	localparam logic [IDX_W-1:0] REG_PULSE_LENGTH = 3'd6;
	localparam logic [IDX_W-1:0] REG_FIX_TIMEOUT  = 3'd7;

	localparam logic [15:0] RST_SPEED_MIN    = 16'd50;
	localparam logic [15:0] RST_SPEED_MAX    = 16'd1500;
	localparam logic [31:0] RST_INTERVAL_MIN = 32'd60000;
	localparam logic [31:0] RST_INTERVAL_MAX = 32'd600000;
	localparam logic [7:0]  RST_DUTY_MIN     = 8'd100;
	localparam logic [7:0]  RST_DUTY_MAX     = 8'd255;
	localparam logic [15:0] RST_PULSE_LENGTH = 16'd500;
	localparam logic [15:0] RST_FIX_TIMEOUT  = 16'd5000;

	localparam int DIV_STEPS = 32;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);

	typedef struct packed {
		logic capture;
		logic step;
		logic prep;
		logic mul;
		logic div_start;
		logic fin;
		logic pump;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic manual;
		logic div_done;
		logic out_stall;
	} status_t;

endpackage

// ----- design/ssps_div.sv -----
// Radix-2 restoring divider producing a 32-bit quotient of a 48-bit dividend by a 16-bit divisor.
module ssps_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [47:0] dividend,
	input  logic [15:0] divisor,
	output logic [31:0] quotient,
	output logic        done
);

	logic [15:0]                    rem_q;
	logic [31:0]                    quo_q;
	logic [15:0]                    dvs_q;
	logic [ssps_pkg::DIV_CNT_W-1:0] cnt_q;
	logic                           busy_q;
	logic                           done_q;
	logic [16:0]                    trial;
	logic [16:0]                    diff;
	logic                           ge;

	assign trial = {rem_q, quo_q[31]};
	assign ge    = trial >= {1'b0, dvs_q};
	assign diff  = trial - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + ssps_pkg::DIV_CNT_W'(1);
				if (cnt_q == ssps_pkg::DIV_CNT_W'(ssps_pkg::DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= dividend[47:32];
			quo_q <= dividend[31:0];
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff[15:0] : trial[15:0];
			quo_q <= {quo_q[30:0], ge};
		end
	end

	assign quotient = quo_q;
	assign done     = done_q;

endmodule

// ----- design/ssps_datapath.sv -----
// Datapath: configuration registers, fix sampling, interpolation arithmetic and pump state.
module ssps_datapath (
	input  logic                       clk,
	input  logic                       arst_n,
	input  ssps_pkg::cmd_t             cmd,
	output ssps_pkg::status_t          status,
	input  logic                       in_func,
	input  logic [ssps_pkg::IN_W-1:0]  in_data,
	input  logic                       cfg_we,
	input  logic [ssps_pkg::IDX_W-1:0] cfg_index,
	input  logic [ssps_pkg::CFG_W-1:0] cfg_data,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [ssps_pkg::OUT_W-1:0] out_data
);

	localparam logic [1:0] SEL_LO  = 2'd0;
	localparam logic [1:0] SEL_HI  = 2'd1;
	localparam logic [1:0] SEL_DIV = 2'd2;

	logic [15:0] speed_min_q, speed_max_q, pulse_length_q, fix_timeout_q;
	logic [31:0] interval_min_q, interval_max_q;
	logic [7:0]  duty_min_q, duty_max_q;

	logic        func_q, lv_q, sv_q, spv_q;
	logic [15:0] age_q, gs_q;
	logic [7:0]  sc_q;

	logic [31:0] now_q, last_sample_q, last_fix_q, last_shot_q, pulse_start_q, next_int_q;
	logic [31:0] shots_q;
	logic [15:0] held_speed_q;
	logic [7:0]  held_sats_q, duty_q;
	logic        fix_q, pulse_q, led_q;

	logic [15:0] num_q, den_q;
	logic [1:0]  sel_q;
	logic        ineg_q, dneg_q;
	logic [31:0] imag_q;
	logic [7:0]  dmag_q;
	logic [47:0] iprod_q, dprod_q;
	logic [31:0] ires_q;
	logic [7:0]  dres_q;

	logic [31:0] iquo, dquo;
	logic        idone, ddone;

	logic [31:0] now_n, since_sample, since_fix, since_shot, since_pulse;
	logic [7:0]  sats_n;
	logic        fix_good;
	logic        oil_ok;
	logic [31:0] to_next;

	logic        out_valid_q;
	logic [ssps_pkg::OUT_W-1:0] out_data_q;

	assign now_n        = now_q + 32'd1;
	assign since_sample = now_n - last_sample_q;
	assign since_fix    = now_n - last_fix_q;
	assign since_shot   = now_q - last_shot_q;
	assign since_pulse  = now_q - pulse_start_q;
	assign sats_n       = sv_q ? sc_q : held_sats_q;
	assign fix_good     = lv_q && (age_q < ssps_pkg::AGE_LIMIT_MS) &&
	                      (sats_n >= ssps_pkg::MIN_SATS);
	assign oil_ok       = fix_q && (held_speed_q >= speed_min_q);

	always_comb begin
		to_next = 32'd0;
		if (oil_ok && (since_shot < next_int_q)) begin
			to_next = next_int_q - since_shot;
		end
	end

	ssps_div u_idiv (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (iprod_q),
		.divisor  (den_q),
		.quotient (iquo),
		.done     (idone)
	);

	ssps_div u_ddiv (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (dprod_q),
		.divisor  (den_q),
		.quotient (dquo),
		.done     (ddone)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			speed_min_q    <= ssps_pkg::RST_SPEED_MIN;
			speed_max_q    <= ssps_pkg::RST_SPEED_MAX;
			interval_min_q <= ssps_pkg::RST_INTERVAL_MIN;
			interval_max_q <= ssps_pkg::RST_INTERVAL_MAX;
			duty_min_q     <= ssps_pkg::RST_DUTY_MIN;
			duty_max_q     <= ssps_pkg::RST_DUTY_MAX;
			pulse_length_q <= ssps_pkg::RST_PULSE_LENGTH;
			fix_timeout_q  <= ssps_pkg::RST_FIX_TIMEOUT;
		end else if (cfg_we) begin
			case (cfg_index)
				ssps_pkg::REG_SPEED_MIN:    speed_min_q    <= cfg_data[15:0];
				ssps_pkg::REG_SPEED_MAX:    speed_max_q    <= cfg_data[15:0];
				ssps_pkg::REG_INTERVAL_MIN: interval_min_q <= cfg_data;
				ssps_pkg::REG_INTERVAL_MAX: interval_max_q <= cfg_data;
				ssps_pkg::REG_DUTY_MIN:     duty_min_q     <= cfg_data[7:0];
				ssps_pkg::REG_DUTY_MAX:     duty_max_q     <= cfg_data[7:0];
				ssps_pkg::REG_PULSE_LENGTH: pulse_length_q <= cfg_data[15:0];
				ssps_pkg::REG_FIX_TIMEOUT:  fix_timeout_q  <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			func_q <= in_func;
			lv_q   <= in_data[0];
			age_q  <= in_data[16:1];
			sv_q   <= in_data[17];
			sc_q   <= in_data[25:18];
			spv_q  <= in_data[26];
			gs_q   <= in_data[42:27];
		end
		if (cmd.prep) begin
			num_q  <= held_speed_q - speed_min_q;
			den_q  <= speed_max_q - speed_min_q;
			ineg_q <= interval_min_q < interval_max_q;
			imag_q <= (interval_min_q < interval_max_q) ? interval_max_q - interval_min_q
			                                            : interval_min_q - interval_max_q;
			dneg_q <= duty_max_q < duty_min_q;
			dmag_q <= (duty_max_q < duty_min_q) ? duty_min_q - duty_max_q
			                                    : duty_max_q - duty_min_q;
			if (speed_max_q == speed_min_q) begin
				sel_q <= SEL_HI;
			end else if ((speed_max_q < speed_min_q) || (held_speed_q <= speed_min_q)) begin
				sel_q <= SEL_LO;
			end else if (held_speed_q >= speed_max_q) begin
				sel_q <= SEL_HI;
			end else begin
				sel_q <= SEL_DIV;
			end
		end
		if (cmd.mul) begin
			iprod_q <= 48'(imag_q) * 48'(num_q);
			dprod_q <= 48'(dmag_q) * 48'(num_q);
		end
		if (cmd.fin) begin
			case (sel_q)
				SEL_HI: begin
					ires_q <= interval_min_q;
					dres_q <= duty_max_q;
				end
				SEL_DIV: begin
					ires_q <= ineg_q ? interval_max_q - iquo : interval_max_q + iquo;
					dres_q <= dneg_q ? duty_min_q - dquo[7:0] : duty_min_q + dquo[7:0];
				end
				default: begin
					ires_q <= interval_max_q;
					dres_q <= duty_min_q;
				end
			endcase
		end
		if (cmd.load_out) begin
			out_data_q <= {5'd0, held_speed_q, to_next, shots_q, led_q, fix_q, pulse_q, duty_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			now_q         <= '0;
			last_sample_q <= '0;
			last_fix_q    <= '0;
			last_shot_q   <= '0;
			pulse_start_q <= '0;
			next_int_q    <= ssps_pkg::RST_INTERVAL_MAX;
			shots_q       <= '0;
			held_speed_q  <= '0;
			held_sats_q   <= '0;
			duty_q        <= '0;
			fix_q         <= 1'b0;
			pulse_q       <= 1'b0;
			led_q         <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			if (cmd.step) begin
				if (func_q) begin
					if (!pulse_q) begin
						duty_q        <= duty_min_q;
						pulse_q       <= 1'b1;
						pulse_start_q <= now_q;
						shots_q       <= shots_q + 32'd1;
					end
				end else begin
					now_q <= now_n;
					if (since_sample >= ssps_pkg::SAMPLE_PERIOD_MS) begin
						last_sample_q <= now_n;
						held_sats_q   <= sats_n;
						if (fix_good) begin
							fix_q      <= 1'b1;
							last_fix_q <= now_n;
							if (spv_q) begin
								held_speed_q <= (gs_q > speed_max_q) ? speed_max_q : gs_q;
							end
							led_q <= !led_q;
						end else if (since_fix > {16'd0, fix_timeout_q}) begin
							fix_q        <= 1'b0;
							held_speed_q <= '0;
							led_q        <= 1'b0;
						end
					end
				end
			end
			if (cmd.pump) begin
				if (pulse_q) begin
					if (since_pulse >= {16'd0, pulse_length_q}) begin
						pulse_q <= 1'b0;
						duty_q  <= '0;
					end
				end else if (oil_ok) begin
					next_int_q <= ires_q;
					if (since_shot >= ires_q) begin
						duty_q <= dres_q;
						if (dres_q != 8'd0) begin
							pulse_q       <= 1'b1;
							pulse_start_q <= now_q;
							last_shot_q   <= now_q;
							shots_q       <= shots_q + 32'd1;
						end
					end
				end else begin
					pulse_q <= 1'b0;
					duty_q  <= '0;
				end
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign status.manual    = func_q;
	assign status.div_done  = idone && ddone;
	assign status.out_stall = out_valid_q && !out_ready;

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

// ----- design/ssps_ctrl.sv -----
// Controller: sequences each transfer through sampling, then (ticks only) interpolation and pump update, then output.
module ssps_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  ssps_pkg::status_t status,
	output ssps_pkg::cmd_t    cmd
);

	localparam logic [3:0] ST_IDLE   = 4'd0;
	localparam logic [3:0] ST_STEP   = 4'd1;
	localparam logic [3:0] ST_PREP   = 4'd2;
	localparam logic [3:0] ST_MUL    = 4'd3;
	localparam logic [3:0] ST_DSTART = 4'd4;
	localparam logic [3:0] ST_DWAIT  = 4'd5;
	localparam logic [3:0] ST_FIN    = 4'd6;
	localparam logic [3:0] ST_PUMP   = 4'd7;
	localparam logic [3:0] ST_OUT    = 4'd8;

	logic [3:0] state_q, state_n;

	always_comb begin
		state_n = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_n     = ST_STEP;
				end
			end
			ST_STEP: begin
				cmd.step = 1'b1;
				state_n  = status.manual ? ST_OUT : ST_PREP;
			end
			ST_PREP: begin
				cmd.prep = 1'b1;
				state_n  = ST_MUL;
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				state_n = ST_DSTART;
			end
			ST_DSTART: begin
				cmd.div_start = 1'b1;
				state_n       = ST_DWAIT;
			end
			ST_DWAIT: begin
				if (status.div_done) begin
					state_n = ST_FIN;
				end
			end
			ST_FIN: begin
				cmd.fin = 1'b1;
				state_n = ST_PUMP;
			end
			ST_PUMP: begin
				cmd.pump = 1'b1;
				state_n  = ST_OUT;
			end
			ST_OUT: begin
				if (!status.out_stall) begin
					cmd.load_out = 1'b1;
					state_n      = ST_IDLE;
				end
			end
			default: begin
				state_n = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	assign in_ready = (state_q == ST_IDLE);

endmodule

// ----- design/speed_scaled_pulse_scheduler_unit.sv -----
// Top level of the speed-scaled pump pulse scheduler.
// One item is in work at a time. A tick transfer (tuser low) goes from acceptance to its
// result in the output register through sampling, a multiply, then a 32-step
// radix-2 divide that computes the interpolated interval and duty side by side, then the pump
// update. A manual shot transfer (tuser high) skips the arithmetic and the pump update. The next
// item can be accepted at the edge after the result is loaded, even while it waits on m_tready;
// a new result that finds the old one still waiting holds until it leaves. Configuration writes
// are always ready and take effect in the cycle after the transfer.
module speed_scaled_pulse_scheduler_unit (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_tvalid,
	output logic                       s_tready,
	// [0] location_valid, [16:1] location_age, [17] sats_valid, [25:18] sat_count,
	// [26] speed_valid, [42:27] ground_speed, [47:43] zero
	input  logic [ssps_pkg::IN_W-1:0]  s_tdata,
	// [0] func
	input  logic                       s_tuser,
	output logic                       m_tvalid,
	input  logic                       m_tready,
	// [7:0] pump_duty, [8] pump_on, [9] fix_ok, [10] status_led, [42:11] shot_total,
	// [74:43] ms_to_next, [90:75] speed_now, [95:91] zero
	output logic [ssps_pkg::OUT_W-1:0] m_tdata,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [ssps_pkg::IDX_W-1:0] cfg_index,
	input  logic [ssps_pkg::CFG_W-1:0] cfg_data
);

	ssps_pkg::cmd_t    cmd;
	ssps_pkg::status_t status;

	assign cfg_ready = 1'b1;

	ssps_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.status   (status),
		.cmd      (cmd)
	);

	ssps_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.in_func   (s_tuser),
		.in_data   (s_tdata),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (m_tdata)
	);

	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input accepted while an item is in work");

	a_duty_needs_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[7:0] != 8'd0) |-> m_tdata[8])
		else $error("nonzero pump duty without a pulse");

	a_speed_needs_fix: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[9] |-> (m_tdata[90:75] == 16'd0))
		else $error("speed held without a valid fix");

	a_countdown_needs_fix: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[74:43] != 32'd0) |-> m_tdata[9])
		else $error("shot countdown without a valid fix");

endmodule

// ----- tb/tb_speed_scaled_pulse_scheduler_unit.sv -----
// Testbench of the speed-scaled pulse scheduler: directed table, then random items and a predictor.
`timescale 1ns / 1ps

module tb_speed_scaled_pulse_scheduler_unit;

	typedef struct packed {
		logic        func;
		logic        lv;
		logic [15:0] age;
		logic        sv;
		logic [7:0]  sc;
		logic        spv;
		logic [15:0] gs;
	} fix_item_t;

	typedef struct packed {
		logic [7:0]  duty;
		logic        on;
		logic        fix;
		logic        led;
		logic [31:0] shots;
		logic [31:0] to_next;
		logic [15:0] speed;
	} pump_out_t;

	typedef struct {
		fix_item_t item;
		int        rep;
		bit        chk;
		pump_out_t want;
	} plan_row_t;

	localparam int N_PHASES    = 8;
	localparam int PHASE_ITEMS = 60;

	logic                       clk = 1'b0;
	logic                       arst_n;
	logic                       s_tvalid;
	logic                       s_tready;
	logic [ssps_pkg::IN_W-1:0]  s_tdata;
	logic                       s_tuser;
	logic                       m_tvalid;
	logic                       m_tready;
	logic [ssps_pkg::OUT_W-1:0] m_tdata;
	logic                       cfg_valid;
	logic                       cfg_ready;
	logic [ssps_pkg::IDX_W-1:0] cfg_index;
	logic [ssps_pkg::CFG_W-1:0] cfg_data;

	speed_scaled_pulse_scheduler_unit dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #4 clk = ~clk;

	// predictor configuration shadow
	logic [15:0] c_spd_lo, c_spd_hi, c_pulse_len, c_fix_tmo;
	logic [31:0] c_ivl_lo, c_ivl_hi;
	logic [7:0]  c_duty_lo, c_duty_hi;

	// predictor state
	logic [31:0] clk_ms, sample_mark, fix_mark, shot_mark, pulse_mark, gap_ms, shots;
	logic [15:0] spd_held;
	logic [7:0]  sats_held, duty_now;
	logic        have_fix, pulsing, led;

	pump_out_t pump_q[$];
	int        n_errs, n_checked, n_items, n_manual, n_settings;
	bit        quiet;
	int        stretch;
	int        hold_off;

	function automatic longint lerp(longint lo, longint hi, longint spd);
		longint sl, sh, num, den;
		sl = c_spd_lo;
		sh = c_spd_hi;
		if (sh == sl) return hi;
		if (sh < sl || spd <= sl) return lo;
		num = spd - sl;
		den = sh - sl;
		if (num >= den) return hi;
		return lo + ((hi - lo) * num) / den;
	endfunction

	function automatic pump_out_t pump_step(fix_item_t it);
		pump_out_t   o;
		logic [31:0] el;
		longint      v;
		if (it.func) begin
			if (!pulsing) begin
				duty_now = c_duty_lo;
				pulsing = 1'b1;
				pulse_mark = clk_ms;
				shots = shots + 32'd1;
			end
		end else begin
			clk_ms = clk_ms + 32'd1;
			el = clk_ms - sample_mark;
			if (el >= ssps_pkg::SAMPLE_PERIOD_MS) begin
				sample_mark = clk_ms;
				if (it.sv) sats_held = it.sc;
				if (it.lv && it.age < ssps_pkg::AGE_LIMIT_MS &&
						sats_held >= ssps_pkg::MIN_SATS) begin
					have_fix = 1'b1;
					fix_mark = clk_ms;
					if (it.spv) spd_held = (it.gs > c_spd_hi) ? c_spd_hi : it.gs;
					led = !led;
				end else begin
					el = clk_ms - fix_mark;
					if (el > {16'd0, c_fix_tmo}) begin
						have_fix = 1'b0;
						spd_held = '0;
						led = 1'b0;
					end
				end
			end
			if (pulsing) begin
				el = clk_ms - pulse_mark;
				if (el >= {16'd0, c_pulse_len}) begin
					pulsing = 1'b0;
					duty_now = '0;
				end
			end else if (have_fix && spd_held >= c_spd_lo) begin
				v = lerp(c_ivl_hi, c_ivl_lo, spd_held);
				gap_ms = v[31:0];
				el = clk_ms - shot_mark;
				if (el >= gap_ms) begin
					v = lerp(c_duty_lo, c_duty_hi, spd_held);
					duty_now = v[7:0];
					if (duty_now != 8'd0) begin
						pulsing = 1'b1;
						pulse_mark = clk_ms;
						shot_mark = clk_ms;
						shots = shots + 32'd1;
					end
				end
			end else begin
				pulsing = 1'b0;
				duty_now = '0;
			end
		end
		o.to_next = '0;
		if (have_fix && spd_held >= c_spd_lo) begin
			el = clk_ms - shot_mark;
			if (el < gap_ms) o.to_next = gap_ms - el;
		end
		o.duty = duty_now;
		o.on = pulsing;
		o.fix = have_fix;
		o.led = led;
		o.shots = shots;
		o.speed = spd_held;
		return o;
	endfunction

	function automatic pump_out_t outv(logic [7:0] duty, logic on, logic fix, logic lamp,
			logic [31:0] cnt, logic [31:0] nxt, logic [15:0] spd);
		pump_out_t o;
		o.duty = duty;
		o.on = on;
		o.fix = fix;
		o.led = lamp;
		o.shots = cnt;
		o.to_next = nxt;
		o.speed = spd;
		return o;
	endfunction

	function automatic plan_row_t row(logic func, logic lv, logic [15:0] age, logic sv,
			logic [7:0] sc, logic spv, logic [15:0] gs, int rep, bit chk, pump_out_t want);
		plan_row_t r;
		r.item = '{func: func, lv: lv, age: age, sv: sv, sc: sc, spv: spv, gs: gs};
		r.rep = rep;
		r.chk = chk;
		r.want = want;
		return r;
	endfunction

	function automatic fix_item_t draw_item();
		fix_item_t it;
		int        top;
		int        k;
		top = int'((c_spd_hi > c_spd_lo) ? c_spd_hi : c_spd_lo) + 50;
		if (top > 65535) top = 65535;
		it.func = ($urandom_range(0, 99) < 4);
		if ($urandom_range(0, 99) < 20) begin
			it.lv = 1'($urandom);
			it.age = 16'($urandom);
			it.sv = 1'($urandom);
			it.sc = 8'($urandom);
			it.spv = 1'($urandom);
			it.gs = 16'($urandom);
		end else begin
			it.lv = ($urandom_range(0, 9) != 0);
			k = $urandom_range(0, 9);
			it.age = (k == 0) ? 16'd2000 : (k == 1) ? 16'd1999 : 16'($urandom_range(0, 1999));
			it.sv = ($urandom_range(0, 4) != 0);
			it.sc = ($urandom_range(0, 5) == 0) ? 8'($urandom_range(0, 3))
				: 8'($urandom_range(4, 255));
			it.spv = ($urandom_range(0, 7) != 0);
			it.gs = ($urandom_range(0, 4) == 0) ? 16'($urandom)
				: 16'($urandom_range(0, top));
		end
		return it;
	endfunction

	task automatic cfg_write(input logic [ssps_pkg::IDX_W-1:0] idx,
			input logic [ssps_pkg::CFG_W-1:0] val);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			ssps_pkg::REG_SPEED_MIN:    c_spd_lo = val[15:0];
			ssps_pkg::REG_SPEED_MAX:    c_spd_hi = val[15:0];
			ssps_pkg::REG_INTERVAL_MIN: c_ivl_lo = val;
			ssps_pkg::REG_INTERVAL_MAX: c_ivl_hi = val;
			ssps_pkg::REG_DUTY_MIN:     c_duty_lo = val[7:0];
			ssps_pkg::REG_DUTY_MAX:     c_duty_hi = val[7:0];
			ssps_pkg::REG_PULSE_LENGTH: c_pulse_len = val[15:0];
			ssps_pkg::REG_FIX_TIMEOUT:  c_fix_tmo = val[15:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic transfer_item(input fix_item_t it, input bit typed, input pump_out_t want);
		int        gap;
		pump_out_t pred;
		if (stretch <= 0) begin
			stretch = $urandom_range(50, 300);
			quiet = ($urandom_range(0, 2) == 0);
		end
		stretch--;
		gap = quiet ? 0 : $urandom_range(0, 14);
		@(negedge clk);
		if (gap > 0) begin
			s_tvalid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tuser = it.func;
		s_tdata = {5'd0, it.gs, it.spv, it.sc, it.sv, it.age, it.lv};
		do @(posedge clk); while (!s_tready);
		pred = pump_step(it);
		pump_q.push_back(typed ? want : pred);
		n_items++;
		if (it.func) n_manual++;
	endtask

	task automatic wait_idle();
		@(negedge clk);
		s_tvalid = 1'b0;
		while (pump_q.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	// result checker
	always @(posedge clk) begin
		pump_out_t got;
		pump_out_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got.duty = m_tdata[7:0];
			got.on = m_tdata[8];
			got.fix = m_tdata[9];
			got.led = m_tdata[10];
			got.shots = m_tdata[42:11];
			got.to_next = m_tdata[74:43];
			got.speed = m_tdata[90:75];
			if (pump_q.size() == 0) begin
				n_errs++;
				if (n_errs <= 10) $display("unexpected result transfer: %p", got);
			end else begin
				want = pump_q.pop_front();
				n_checked++;
				if (got.duty !== want.duty || got.on !== want.on || got.fix !== want.fix ||
						got.led !== want.led || got.shots !== want.shots ||
						got.to_next !== want.to_next || got.speed !== want.speed) begin
					n_errs++;
					if (n_errs <= 10) begin
						$display("mismatch on result %0d", n_checked);
						$display("  expected duty=%0d on=%0d fix=%0d led=%0d",
							want.duty, want.on, want.fix, want.led);
						$display("           shots=%0d next=%0d speed=%0d",
							want.shots, want.to_next, want.speed);
						$display("  actual   duty=%0d on=%0d fix=%0d led=%0d",
							got.duty, got.on, got.fix, got.led);
						$display("           shots=%0d next=%0d speed=%0d",
							got.shots, got.to_next, got.speed);
					end
				end
			end
		end
	end

	// result receiver
	initial begin
		int stall;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_off > 0) begin
				m_tready = 1'b0;
				repeat (hold_off) @(negedge clk);
				hold_off = 0;
			end
			stall = quiet ? 0 : $urandom_range(0, 14);
			if (stall > 0) begin
				m_tready = 1'b0;
				repeat (stall) @(negedge clk);
			end
			m_tready = 1'b1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	initial begin
		#5_000_000;
		$display("TEST FAILED");
		$finish;
	end

	initial begin
		plan_row_t   plan[$];
		logic [31:0] setv [N_PHASES];
		pump_out_t   zero_out;
		int          waited;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		n_errs = 0;
		n_checked = 0;
		n_items = 0;
		n_manual = 0;
		n_settings = 1;
		quiet = 1'b0;
		stretch = 0;
		hold_off = 0;

		c_spd_lo = ssps_pkg::RST_SPEED_MIN;
		c_spd_hi = ssps_pkg::RST_SPEED_MAX;
		c_ivl_lo = ssps_pkg::RST_INTERVAL_MIN;
		c_ivl_hi = ssps_pkg::RST_INTERVAL_MAX;
		c_duty_lo = ssps_pkg::RST_DUTY_MIN;
		c_duty_hi = ssps_pkg::RST_DUTY_MAX;
		c_pulse_len = ssps_pkg::RST_PULSE_LENGTH;
		c_fix_tmo = ssps_pkg::RST_FIX_TIMEOUT;
		clk_ms = '0;
		sample_mark = '0;
		fix_mark = '0;
		shot_mark = '0;
		pulse_mark = '0;
		gap_ms = ssps_pkg::RST_INTERVAL_MAX;
		shots = '0;
		spd_held = '0;
		sats_held = '0;
		duty_now = '0;
		have_fix = 1'b0;
		pulsing = 1'b0;
		led = 1'b0;

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		repeat (3) @(posedge clk);

		zero_out = '0;
		plan.push_back(row(1'b0, 1'b0, 16'h0000, 1'b0, 8'h00, 1'b0, 16'h0000, 1, 1'b1,
			zero_out));
		plan.push_back(row(1'b0, 1'b1, 16'hffff, 1'b1, 8'hff, 1'b1, 16'hffff, 1, 1'b1,
			zero_out));
		plan.push_back(row(1'b1, 1'b0, 16'h0000, 1'b0, 8'h00, 1'b0, 16'h0000, 1, 1'b1,
			outv(ssps_pkg::RST_DUTY_MIN, 1'b1, 1'b0, 1'b0, 32'd1, 32'd0, 16'd0)));
		// pulse already running: no new shot
		plan.push_back(row(1'b1, 1'b1, 16'hffff, 1'b1, 8'hff, 1'b1, 16'hffff, 1, 1'b1,
			outv(ssps_pkg::RST_DUTY_MIN, 1'b1, 1'b0, 1'b0, 32'd1, 32'd0, 16'd0)));
		plan.push_back(row(1'b0, 1'b0, 16'h0000, 1'b0, 8'h00, 1'b0, 16'h0000, 1, 1'b1,
			outv(ssps_pkg::RST_DUTY_MIN, 1'b1, 1'b0, 1'b0, 32'd1, 32'd0, 16'd0)));
		plan.push_back(row(1'b0, 1'b0, 16'h0000, 1'b0, 8'h00, 1'b0, 16'h0000, 996, 1'b0,
			zero_out));
		// first sample: fix at the minimum satellite count, speed clamped to speed_max
		plan.push_back(row(1'b0, 1'b1, 16'h0000, 1'b1, 8'd4, 1'b1, 16'hffff, 1, 1'b1,
			outv(8'd0, 1'b0, 1'b1, 1'b1, 32'd1, ssps_pkg::RST_INTERVAL_MIN - 32'd1000,
				ssps_pkg::RST_SPEED_MAX)));

		foreach (plan[i]) begin
			for (int k = 0; k < plan[i].rep; k++)
				transfer_item(plan[i].item, plan[i].chk, plan[i].want);
		end

		// register values listed by register index
		for (int ph = 0; ph < N_PHASES; ph++) begin
			wait_idle();
			case (ph)
				0: setv = '{50, 1500, 20, 400, 100, 255, 30, 5000};
				1: setv = '{0, 65535, 0, 32'hffffffff, 0, 255, 0, 0};
				// zero speed span
				2: setv = '{800, 800, 5, 100, 255, 1, 7, 1000};
				// inverted speed span
				3: setv = '{1200, 300, 10, 50, 30, 200, 5, 65535};
				// inverted interval and duty limits
				4: setv = '{100, 2000, 300, 15, 250, 3, 12, 999};
				// duty zero on both manual and automatic shots
				5: setv = '{0, 400, 1, 40, 0, 0, 3, 1000};
				6: setv = '{$urandom_range(0, 1500), $urandom_range(0, 3000),
					$urandom_range(0, 300), $urandom_range(0, 300),
					$urandom_range(0, 255), $urandom_range(0, 255),
					$urandom_range(0, 100), $urandom_range(0, 3000)};
				default: setv = '{65535, 65535, 32'hffffffff, 32'hffffffff,
					255, 255, 65535, 65535};
			endcase
			foreach (setv[r])
				cfg_write(ssps_pkg::IDX_W'(r), setv[r]);
			n_settings++;
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				// stall the result side long enough to back up the input
				if (ph == 2 && k == 20) hold_off = 600;
				transfer_item(draw_item(), 1'b0, zero_out);
			end
		end

		@(negedge clk);
		s_tvalid = 1'b0;
		waited = 0;
		while (pump_q.size() != 0 && waited < 50000) begin
			@(posedge clk);
			waited++;
		end
		repeat (100) @(posedge clk);
		if (pump_q.size() != 0) begin
			$display("%0d expected results never arrived", pump_q.size());
			n_errs += pump_q.size();
		end

		$display("sent %0d items (%0d manual shot requests) under %0d register settings",
			n_items, n_manual, n_settings);
		$display("checked %0d results, %0d pump shots predicted, %0d mismatches",
			n_checked, shots, n_errs);
		if (n_errs == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
